// File: sv/ugbi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ugbi_pkg
// Shared constants for the uniform grid bin index unit.
// ----------------------------------------------------------------------------
package ugbi_pkg;

	localparam int POS_W  = 24;
	localparam int EDGE_W = 23;
	localparam int DVD_W  = 26;

	localparam int DEF_MAX_BOXES   = 256;
	localparam int DEF_MAX_COLUMNS = 32;
	localparam int DEF_MAX_ROWS    = 32;
	localparam int DEF_MAX_ENTRIES = 4096;

	localparam logic [1:0] FN_LOAD  = 2'd0;
	localparam logic [1:0] FN_COUNT = 2'd1;
	localparam logic [1:0] FN_READ  = 2'd2;
	localparam logic [1:0] FN_NOP   = 2'd3;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_OUTSIDE  = 3'd1;
	localparam logic [2:0] ST_FULL     = 3'd2;
	localparam logic [2:0] ST_OVERFLOW = 3'd3;
	localparam logic [2:0] ST_BAD_CELL = 3'd4;
	localparam logic [2:0] ST_BAD_SLOT = 3'd5;

	localparam logic [2:0] REG_MIN_X = 3'd0;
	localparam logic [2:0] REG_MIN_Y = 3'd1;
	localparam logic [2:0] REG_MAX_X = 3'd2;
	localparam logic [2:0] REG_MAX_Y = 3'd3;
	localparam logic [2:0] REG_EDGE  = 3'd4;

endpackage

// File: sv/uniform_grid_bin_index_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uniform_grid_bin_index_unit
// Uniform grid spatial index built by counting sort over loaded boxes.
// A load runs four divisions, one per box edge; a build then clears the cell
// counts, counts the covered cells of each box, forms the prefix sum and scatters
// the box numbers in a second pass; an overflow clears again.
// A start is taken only while idle; a register write also makes the unit busy.
// After reset the cell offset memory is cleared, and the unit is busy meanwhile.
// ----------------------------------------------------------------------------
module uniform_grid_bin_index_unit import ugbi_pkg::*; #(
	parameter int MAX_BOXES   = DEF_MAX_BOXES,
	parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
	parameter int MAX_ROWS    = DEF_MAX_ROWS,
	parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         func,
	input  logic signed [23:0] box_min_x,
	input  logic signed [23:0] box_min_y,
	input  logic signed [23:0] box_max_x,
	input  logic signed [23:0] box_max_y,
	input  logic               last_box,
	input  logic [4:0]         query_col,
	input  logic [4:0]         query_row,
	input  logic [11:0]        slot,
	output logic               done,
	output logic [2:0]         status,
	output logic [7:0]         record_number,
	output logic [12:0]        entry_count,
	output logic [4:0]         range_min_col,
	output logic [4:0]         range_min_row,
	output logic [4:0]         range_max_col,
	output logic [4:0]         range_max_row,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [23:0]        cfg_data
);

	localparam int NCELLS = MAX_COLUMNS * MAX_ROWS;
	localparam int XW  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam int YW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int WW  = (XW > YW) ? XW : YW;
	localparam int CNW = $clog2(MAX_COLUMNS + 1);
	localparam int RNW = $clog2(MAX_ROWS + 1);
	localparam int CAW = $clog2(NCELLS + 1);
	localparam int FAW = (NCELLS > 1) ? $clog2(NCELLS) : 1;
	localparam int EAW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int SW  = $clog2(((MAX_ENTRIES > MAX_BOXES) ? MAX_ENTRIES : MAX_BOXES) + 1);
	localparam int BLW = $clog2(MAX_BOXES + 1);
	localparam int BAW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
	localparam int RST_COLS = (MAX_COLUMNS < 32) ? MAX_COLUMNS : 32;
	localparam int RST_ROWS = (MAX_ROWS < 32) ? MAX_ROWS : 32;

	typedef enum logic [16:0] {
		S_IDLE   = 17'h00001,
		S_CLR    = 17'h00002,
		S_RNG    = 17'h00004,
		S_EVAL   = 17'h00008,
		S_FETCH  = 17'h00010,
		S_BWAIT  = 17'h00020,
		S_CNT_RD = 17'h00040,
		S_CNT_WR = 17'h00080,
		S_PFX_RD = 17'h00100,
		S_PFX_WR = 17'h00200,
		S_SCT_RD = 17'h00400,
		S_SCT_WR = 17'h00800,
		S_Q0     = 17'h01000,
		S_Q1     = 17'h02000,
		S_Q2     = 17'h04000,
		S_Q3     = 17'h08000,
		S_DONE   = 17'h10000
	} state_t;

	state_t state_q, ret_q;

	logic signed [23:0] gminx_q, gminy_q, gmaxx_q, gmaxy_q;
	logic [22:0]        edge_q;
	logic [CNW-1:0]     cols_q;
	logic [RNW-1:0]     rows_q;
	logic [BLW-1:0]     bl_q, i_q;
	logic signed [23:0] box_q [4];
	logic [1:0]         func_q;
	logic               last_q;
	logic [11:0]        slot_q;
	logic [WW-1:0]      w_q [4];
	logic [1:0]         k_q;
	logic               lay_q, run_q, bld_q, pass_q, ovf_q;
	logic [XW-1:0]      x_q;
	logic [YW-1:0]      y_q;
	logic [CAW-1:0]     cell_q, p_q, clr_q;
	logic [SW-1:0]      acc_q, start_q;
	logic [2:0]         st_q;
	logic [7:0]         rec_q;
	logic [12:0]        cnt_q;
	logic [4:0]         rr_q [4];

	logic [95:0]        box_mem [MAX_BOXES];
	logic [SW-1:0]      cs_mem [NCELLS + 1];
	logic [SW-1:0]      fc_mem [NCELLS];
	logic [7:0]         es_mem [MAX_ENTRIES];
	logic [95:0]        bs_rd;
	logic [SW-1:0]      cs_rd, fc_rd;
	logic [7:0]         es_rd;

	logic               bs_we, cs_we, fc_we, es_we;
	logic [CAW-1:0]     cs_wa, cs_ra;
	logic [SW-1:0]      cs_wd, fc_wd;
	logic [FAW-1:0]     fc_wa, fc_ra;
	logic [EAW-1:0]     es_ra;

	logic               accept;
	logic [22:0]        edge_eff;
	logic signed [23:0] lo, hi;
	logic signed [24:0] span, dpos;
	logic               span_pos;
	logic [DVD_W-1:0]   dvd;
	logic               dgo, ddone;
	logic [DVD_W-1:0]   quo;
	logic [CAW-1:0]     cidx;
	logic               outside;
	logic [SW:0]        psum;
	logic [SW-1:0]      qn;
	logic [1:0]         k_last;

	assign busy          = (state_q != S_IDLE);
	assign accept        = start && (state_q == S_IDLE);
	assign cfg_ready     = (state_q == S_IDLE) && !start;
	assign done          = (state_q == S_DONE);
	assign status        = st_q;
	assign record_number = rec_q;
	assign entry_count   = cnt_q;
	assign range_min_col = rr_q[0];
	assign range_min_row = rr_q[1];
	assign range_max_col = rr_q[2];
	assign range_max_row = rr_q[3];

	assign edge_eff = (edge_q == '0) ? 23'd1 : edge_q;
	assign lo       = k_q[0] ? gminy_q : gminx_q;
	assign hi       = k_q[0] ? gmaxy_q : gmaxx_q;
	assign span     = {hi[23], hi} - {lo[23], lo};
	assign span_pos = !span[24] && (span != '0);
	assign dpos     = {box_q[k_q][23], box_q[k_q]} - {lo[23], lo};
	assign k_last   = lay_q ? 2'd1 : 2'd3;

	always_comb begin
		if (lay_q) begin
			dvd = span_pos ? (DVD_W'(span) + DVD_W'(edge_eff) - DVD_W'(1)) : '0;
		end else begin
			dvd = dpos[24] ? '0 : DVD_W'(dpos);
		end
	end

	assign dgo = (state_q == S_RNG) && !run_q;

	ugbi_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (dgo),
		.dividend (dvd),
		.divisor  (edge_eff),
		.done     (ddone),
		.quotient (quo)
	);

	assign cidx = CAW'(32'(y_q) * 32'(cols_q) + 32'(x_q));
	assign outside = (box_q[2] < gminx_q) || (box_q[0] > gmaxx_q) ||
		(box_q[3] < gminy_q) || (box_q[1] > gmaxy_q);
	assign psum = {1'b0, acc_q} + {1'b0, cs_rd};
	assign qn   = cs_rd - start_q;

	always_comb begin
		bs_we = accept && (func == FN_LOAD) && (32'(bl_q) < MAX_BOXES);
		cs_we = 1'b0;
		cs_wa = cell_q;
		cs_wd = '0;
		cs_ra = cell_q;
		fc_we = 1'b0;
		fc_wa = cell_q[FAW-1:0];
		fc_wd = fc_rd + SW'(1);
		fc_ra = cidx[FAW-1:0];
		es_we = 1'b0;
		es_ra = EAW'(32'(start_q) + 32'(slot_q));
		case (state_q)
			S_CLR: begin
				cs_we = 1'b1;
				cs_wa = clr_q;
			end
			S_CNT_RD: begin
				cs_ra = cidx + CAW'(1);
			end
			S_CNT_WR: begin
				cs_we = 1'b1;
				cs_wd = cs_rd + SW'(1);
			end
			S_PFX_RD: begin
				cs_ra = p_q;
			end
			S_PFX_WR: begin
				cs_we = 1'b1;
				cs_wa = p_q;
				cs_wd = psum[SW-1:0];
				fc_we = (32'(p_q) < NCELLS);
				fc_wa = p_q[FAW-1:0];
				fc_wd = psum[SW-1:0];
			end
			S_SCT_WR: begin
				fc_we = 1'b1;
				es_we = 1'b1;
			end
			S_Q1: begin
				cs_ra = cell_q + CAW'(1);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (bs_we) begin
			box_mem[bl_q[BAW-1:0]] <= {box_max_y, box_max_x, box_min_y, box_min_x};
		end
		bs_rd <= box_mem[i_q[BAW-1:0]];
		if (cs_we) begin
			cs_mem[cs_wa] <= cs_wd;
		end
		cs_rd <= cs_mem[cs_ra];
		if (fc_we) begin
			fc_mem[fc_wa] <= fc_wd;
		end
		fc_rd <= fc_mem[fc_ra];
		if (es_we) begin
			es_mem[fc_rd[EAW-1:0]] <= i_q[7:0];
		end
		es_rd <= es_mem[es_ra];
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			box_q[0] <= box_min_x;
			box_q[1] <= box_min_y;
			box_q[2] <= box_max_x;
			box_q[3] <= box_max_y;
			func_q   <= func;
			last_q   <= last_box;
			slot_q   <= slot;
		end else if (state_q == S_BWAIT) begin
			box_q[0] <= bs_rd[23:0];
			box_q[1] <= bs_rd[47:24];
			box_q[2] <= bs_rd[71:48];
			box_q[3] <= bs_rd[95:72];
		end
		if (state_q == S_RNG && run_q && ddone && !lay_q) begin
			if (dpos[24]) begin
				w_q[k_q] <= '0;
			end else if (k_q[0] ? (quo > DVD_W'(rows_q - 1'b1))
				: (quo > DVD_W'(cols_q - 1'b1))) begin
				w_q[k_q] <= k_q[0] ? WW'(rows_q - 1'b1) : WW'(cols_q - 1'b1);
			end else begin
				w_q[k_q] <= WW'(quo);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			ret_q   <= S_IDLE;
			clr_q   <= '0;
			gminx_q <= 24'sd0;
			gminy_q <= 24'sd0;
			gmaxx_q <= 24'sd8192;
			gmaxy_q <= 24'sd8192;
			edge_q  <= 23'd256;
			cols_q  <= CNW'(RST_COLS);
			rows_q  <= RNW'(RST_ROWS);
			bl_q    <= '0;
			i_q     <= '0;
			k_q     <= '0;
			lay_q   <= 1'b0;
			run_q   <= 1'b0;
			bld_q   <= 1'b0;
			pass_q  <= 1'b0;
			ovf_q   <= 1'b0;
			x_q     <= '0;
			y_q     <= '0;
			cell_q  <= '0;
			p_q     <= '0;
			acc_q   <= '0;
			start_q <= '0;
			st_q    <= ST_OK;
			rec_q   <= '0;
			cnt_q   <= '0;
			for (int j = 0; j < 4; j++) begin
				rr_q[j] <= '0;
			end
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						cnt_q <= '0;
						for (int j = 0; j < 4; j++) begin
							rr_q[j] <= '0;
						end
						case (func)
							FN_LOAD: begin
								if (32'(bl_q) >= MAX_BOXES) begin
									st_q  <= ST_FULL;
									rec_q <= '0;
									if (last_box) begin
										bld_q   <= 1'b1;
										pass_q  <= 1'b0;
										ovf_q   <= 1'b0;
										i_q     <= '0;
										clr_q   <= '0;
										ret_q   <= S_FETCH;
										state_q <= S_CLR;
									end else begin
										state_q <= S_DONE;
									end
								end else begin
									st_q    <= ST_OK;
									rec_q   <= 8'(bl_q);
									lay_q   <= 1'b0;
									k_q     <= '0;
									state_q <= S_RNG;
								end
							end
							FN_COUNT, FN_READ: begin
								rec_q <= '0;
								if ({6'd0, query_col} >= 11'(cols_q) ||
									{6'd0, query_row} >= 11'(rows_q)) begin
									st_q    <= ST_BAD_CELL;
									state_q <= S_DONE;
								end else begin
									st_q    <= ST_OK;
									cell_q  <= CAW'(32'(query_row) * 32'(cols_q) +
										32'(query_col));
									state_q <= S_Q0;
								end
							end
							default: begin
								st_q    <= ST_OK;
								rec_q   <= '0;
								state_q <= S_DONE;
							end
						endcase
					end else if (cfg_valid) begin
						case (cfg_index)
							REG_MIN_X: gminx_q <= cfg_data;
							REG_MIN_Y: gminy_q <= cfg_data;
							REG_MAX_X: gmaxx_q <= cfg_data;
							REG_MAX_Y: gmaxy_q <= cfg_data;
							REG_EDGE:  edge_q  <= cfg_data[22:0];
							default: begin
							end
						endcase
						lay_q   <= 1'b1;
						k_q     <= '0;
						state_q <= S_RNG;
					end
				end
				S_CLR: begin
					if (32'(clr_q) == NCELLS) begin
						state_q <= ret_q;
					end else begin
						clr_q <= clr_q + 1'b1;
					end
				end
				S_RNG: begin
					if (!run_q) begin
						run_q <= 1'b1;
					end else if (ddone) begin
						run_q <= 1'b0;
						if (lay_q) begin
							if (k_q[0]) begin
								if (!span_pos || quo == '0) begin
									rows_q <= RNW'(1);
								end else if (quo > DVD_W'(MAX_ROWS)) begin
									rows_q <= RNW'(MAX_ROWS);
								end else begin
									rows_q <= RNW'(quo);
								end
							end else begin
								if (!span_pos || quo == '0) begin
									cols_q <= CNW'(1);
								end else if (quo > DVD_W'(MAX_COLUMNS)) begin
									cols_q <= CNW'(MAX_COLUMNS);
								end else begin
									cols_q <= CNW'(quo);
								end
							end
						end
						if (k_q == k_last) begin
							k_q     <= '0;
							state_q <= lay_q ? S_IDLE : S_EVAL;
						end else begin
							k_q <= k_q + 1'b1;
						end
					end
				end
				S_EVAL: begin
					if (bld_q) begin
						if (outside || w_q[0] > w_q[2] || w_q[1] > w_q[3]) begin
							i_q     <= i_q + 1'b1;
							state_q <= S_FETCH;
						end else begin
							x_q     <= XW'(w_q[0]);
							y_q     <= YW'(w_q[1]);
							state_q <= pass_q ? S_SCT_RD : S_CNT_RD;
						end
					end else begin
						if (outside) begin
							st_q <= ST_OUTSIDE;
						end else begin
							for (int j = 0; j < 4; j++) begin
								rr_q[j] <= 5'(w_q[j]);
							end
						end
						bl_q <= bl_q + 1'b1;
						if (last_q) begin
							bld_q   <= 1'b1;
							pass_q  <= 1'b0;
							ovf_q   <= 1'b0;
							i_q     <= '0;
							clr_q   <= '0;
							ret_q   <= S_FETCH;
							state_q <= S_CLR;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_FETCH: begin
					if (i_q == bl_q) begin
						if (!pass_q) begin
							p_q     <= '0;
							acc_q   <= '0;
							state_q <= S_PFX_RD;
						end else begin
							bl_q    <= '0;
							bld_q   <= 1'b0;
							state_q <= S_DONE;
						end
					end else begin
						state_q <= S_BWAIT;
					end
				end
				S_BWAIT: begin
					lay_q   <= 1'b0;
					k_q     <= '0;
					state_q <= S_RNG;
				end
				S_CNT_RD: begin
					cell_q  <= cidx + CAW'(1);
					state_q <= S_CNT_WR;
				end
				S_SCT_RD: begin
					cell_q  <= cidx;
					state_q <= S_SCT_WR;
				end
				S_CNT_WR, S_SCT_WR: begin
					if (WW'(x_q) == w_q[2]) begin
						if (WW'(y_q) == w_q[3]) begin
							i_q     <= i_q + 1'b1;
							state_q <= S_FETCH;
						end else begin
							y_q     <= y_q + 1'b1;
							x_q     <= XW'(w_q[0]);
							state_q <= pass_q ? S_SCT_RD : S_CNT_RD;
						end
					end else begin
						x_q     <= x_q + 1'b1;
						state_q <= pass_q ? S_SCT_RD : S_CNT_RD;
					end
				end
				S_PFX_RD: begin
					state_q <= S_PFX_WR;
				end
				S_PFX_WR: begin
					acc_q <= psum[SW-1:0];
					if (32'(psum) > MAX_ENTRIES) begin
						ovf_q <= 1'b1;
					end
					if (32'(p_q) == NCELLS) begin
						if (ovf_q || 32'(psum) > MAX_ENTRIES) begin
							st_q    <= ST_OVERFLOW;
							cnt_q   <= '0;
							bl_q    <= '0;
							bld_q   <= 1'b0;
							clr_q   <= '0;
							ret_q   <= S_DONE;
							state_q <= S_CLR;
						end else begin
							cnt_q   <= 13'(psum);
							pass_q  <= 1'b1;
							i_q     <= '0;
							state_q <= S_FETCH;
						end
					end else begin
						p_q     <= p_q + 1'b1;
						state_q <= S_PFX_RD;
					end
				end
				S_Q0: begin
					state_q <= S_Q1;
				end
				S_Q1: begin
					start_q <= cs_rd;
					state_q <= S_Q2;
				end
				S_Q2: begin
					cnt_q <= 13'(qn);
					if (func_q == FN_COUNT) begin
						state_q <= S_DONE;
					end else if (32'(slot_q) >= 32'(qn)) begin
						st_q    <= ST_BAD_SLOT;
						state_q <= S_DONE;
					end else begin
						state_q <= S_Q3;
					end
				end
				S_Q3: begin
					rec_q   <= es_rd;
					state_q <= S_DONE;
				end
				S_DONE: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// File: sv/ugbi_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ugbi_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ugbi_div import ugbi_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              go,
	input  logic [DVD_W-1:0]  dividend,
	input  logic [EDGE_W-1:0] divisor,
	output logic              done,
	output logic [DVD_W-1:0]  quotient
);

	localparam int CW = $clog2(DVD_W + 1);

	logic [EDGE_W-1:0] rem_q;
	logic [DVD_W-1:0]  quo_q;
	logic [EDGE_W-1:0] dvs_q;
	logic [CW-1:0]     cnt_q;
	logic              done_q;
	logic [EDGE_W:0]   shifted;
	logic              fits;

	assign shifted  = {rem_q, quo_q[DVD_W-1]};
	assign fits     = shifted >= {1'b0, dvs_q};
	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= !go && (cnt_q == CW'(1));
			if (go) begin
				cnt_q <= CW'(DVD_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? EDGE_W'(shifted - {1'b0, dvs_q}) : shifted[EDGE_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], fits};
		end
	end

endmodule
